>>> hw/rtl/kscan_pkg.sv
// shared constants and types of the key scanner
package kscan_pkg;

  // default count of note keys; two octave buttons follow them
  localparam int unsigned NOTE_KEYS_DEF = 25;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned OCT_W    = 5;
  // signed width of 12*octave + base + key before saturation
  localparam int unsigned SUM_W    = 10;

  // register reset values
  localparam logic [SAMPLE_W-1:0]     THRESH_RST = 12'd4094;
  localparam logic [NOTE_W-1:0]       VEL_RST    = 7'd127;
  localparam logic [NOTE_W-1:0]       BASE_RST   = 7'd24;
  localparam logic signed [OCT_W-1:0] OCT_UP_RST = 5'sd8;
  localparam logic signed [OCT_W-1:0] OCT_LO_RST = -5'sd2;
  localparam logic signed [OCT_W-1:0] OCT_RST    = 5'sd3;

  // highest midi note
  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_VELOCITY  = 3'd1,
    CFG_BASE_NOTE = 3'd2,
    CFG_OCT_UPPER = 3'd3,
    CFG_OCT_LOWER = 3'd4
  } cfg_idx_e;

endpackage

>>> hw/rtl/kscan_if.sv
// handshake channels of the key scanner: key samples, note events, configuration writes
interface kscan_key_if #(
  parameter int unsigned KEY_W = 5
);
  import kscan_pkg::*;
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    key_index;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, key_index, sample, input ready);
  modport sink   (input valid, key_index, sample, output ready);
endinterface

interface kscan_event_if;
  import kscan_pkg::*;
  logic              valid;
  logic              ready;
  logic              note_on;
  logic [NOTE_W-1:0] note_number;
  logic [NOTE_W-1:0] velocity;

  modport source (output valid, note_on, note_number, velocity, input ready);
  modport sink   (input valid, note_on, note_number, velocity, output ready);
endinterface

interface kscan_cfg_if;
  import kscan_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kscan_note_calc.sv
// note number of a key press: 12*octave + base + key, saturated to 0..127
module kscan_note_calc import kscan_pkg::*; #(
  parameter int unsigned KEY_W = 5
) (
  input  logic signed [OCT_W-1:0] octave_i,
  input  logic [NOTE_W-1:0]       base_note_i,
  input  logic [KEY_W-1:0]        key_i,
  output logic [NOTE_W-1:0]       note_o
);

  logic signed [SUM_W-1:0] oct_ext;
  logic signed [SUM_W-1:0] oct_x12;
  logic signed [SUM_W-1:0] sum;

  // octave times twelve as two shifts
  assign oct_ext = SUM_W'(octave_i);
  assign oct_x12 = (oct_ext <<< 3) + (oct_ext <<< 2);

  assign sum = oct_x12
             + $signed({{(SUM_W-NOTE_W){1'b0}}, base_note_i})
             + $signed({{(SUM_W-KEY_W){1'b0}}, key_i});

  // clamp into the midi note range
  always_comb begin
    if (sum < 0) begin
      note_o = '0;
    end else if (sum > $signed({{(SUM_W-NOTE_W){1'b0}}, NOTE_MAX})) begin
      note_o = NOTE_MAX;
    end else begin
      note_o = sum[NOTE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/key_scan_to_midi_note_events_unit.sv
// top level: key samples in, midi note-on / note-off events out
// Takes one key sample word per clock unless the event output stalls, and gives at most one
// note event word per sample through the input register, then the event register. The
// pressed flags and the octave are updated on the clock edge at which a sample leaves the
// input register, so samples of the same key may follow back to back. The note stored at
// a press sits in a small memory that is written at the press and read at the release.
// A stalled event output holds one further sample in the input register before the input
// channel stalls. Configuration is taken in any cycle and must be written while idle.
module key_scan_to_midi_note_events_unit import kscan_pkg::*; #(
  parameter int unsigned NOTE_KEYS = NOTE_KEYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kscan_cfg_if.sink     cfg_i,
  kscan_key_if.sink     key_i,
  kscan_event_if.source evt_o
);

  localparam int unsigned TOTAL_KEYS = NOTE_KEYS + 2;
  localparam int unsigned KEY_W      = $clog2(TOTAL_KEYS);
  localparam int unsigned MEM_AW     = (NOTE_KEYS > 1) ? $clog2(NOTE_KEYS) : 1;
  localparam logic [KEY_W:0]   KEY_LIMIT = (KEY_W+1)'(TOTAL_KEYS);
  localparam logic [KEY_W:0]   NOTE_LIM  = (KEY_W+1)'(NOTE_KEYS);
  localparam logic [KEY_W-1:0] KEY_DOWN  = KEY_W'(NOTE_KEYS);
  localparam logic [KEY_W-1:0] KEY_UP    = KEY_W'(NOTE_KEYS + 1);

  // configuration registers
  logic [SAMPLE_W-1:0]     thresh_q;
  logic [NOTE_W-1:0]       vel_q;
  logic [NOTE_W-1:0]       base_q;
  logic signed [OCT_W-1:0] oct_up_q;
  logic signed [OCT_W-1:0] oct_lo_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      vel_q    <= VEL_RST;
      base_q   <= BASE_RST;
      oct_up_q <= OCT_UP_RST;
      oct_lo_q <= OCT_LO_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_THRESHOLD: thresh_q <= cfg_i.data;
        CFG_VELOCITY:  vel_q    <= cfg_i.data[NOTE_W-1:0];
        CFG_BASE_NOTE: base_q   <= cfg_i.data[NOTE_W-1:0];
        CFG_OCT_UPPER: oct_up_q <= cfg_i.data[OCT_W-1:0];
        CFG_OCT_LOWER: oct_lo_q <= cfg_i.data[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid_q;
  logic [KEY_W-1:0]    s1_key_q;
  logic [SAMPLE_W-1:0] s1_sample_q;

  // event register
  logic              s2_valid_q;
  logic              s2_on_q;
  logic [NOTE_W-1:0] s2_note_q;
  logic [NOTE_W-1:0] s2_vel_q;
  logic [NOTE_W-1:0] rd_q;

  // key state
  logic [TOTAL_KEYS-1:0]   pressed_q;
  logic signed [OCT_W-1:0] octave_q;
  logic [NOTE_W-1:0]       held_mem [NOTE_KEYS];

  logic              advance;
  logic              s1_fire;
  logic              pressed;
  logic              was;
  logic              in_range;
  logic              is_note;
  logic              edge_evt;
  logic [MEM_AW-1:0] mem_addr;
  logic [NOTE_W-1:0] press_note;

  // pipeline moves when the event register is free or being taken
  assign advance     = !s2_valid_q || evt_o.ready;
  assign s1_fire     = s1_valid_q && advance;
  assign key_i.ready = !s1_valid_q || advance;

  // per-sample decode
  assign pressed  = s1_sample_q > thresh_q;
  assign in_range = {1'b0, s1_key_q} < KEY_LIMIT;
  assign is_note  = {1'b0, s1_key_q} < NOTE_LIM;
  assign was      = in_range ? pressed_q[s1_key_q] : 1'b0;
  assign edge_evt = is_note && (pressed != was);
  assign mem_addr = s1_key_q[MEM_AW-1:0];

  kscan_note_calc #(
    .KEY_W (KEY_W)
  ) u_note_calc (
    .octave_i    (octave_q),
    .base_note_i (base_q),
    .key_i       (s1_key_q),
    .note_o      (press_note)
  );

  // input register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (key_i.valid && key_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      s1_key_q    <= key_i.key_index;
      s1_sample_q <= key_i.sample;
    end
  end

  // pressed flags and octave buttons
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      octave_q  <= OCT_RST;
    end else if (s1_fire && in_range) begin
      pressed_q[s1_key_q] <= pressed;
      if (s1_key_q == KEY_UP && pressed && !was && octave_q < oct_up_q) begin
        octave_q <= octave_q + OCT_W'(1);
      end else if (s1_key_q == KEY_DOWN && pressed && !was && octave_q > oct_lo_q) begin
        octave_q <= octave_q - OCT_W'(1);
      end
    end
  end

  // held note memory: written on press, read for the release
  always_ff @(posedge clk_i) begin
    if (s1_fire && edge_evt && pressed) begin
      held_mem[mem_addr] <= press_note;
    end
    if (s1_fire) begin
      rd_q <= held_mem[mem_addr];
    end
  end

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && edge_evt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_on_q   <= pressed;
      s2_note_q <= press_note;
      s2_vel_q  <= vel_q;
    end
  end

  assign evt_o.valid       = s2_valid_q;
  assign evt_o.note_on     = s2_on_q;
  assign evt_o.note_number = s2_on_q ? s2_note_q : rd_q;
  assign evt_o.velocity    = s2_vel_q;

endmodule

>>> sim/key_scan_to_midi_note_events_unit_tb.sv
// self-checking testbench of the key scanner: random key samples, predicted note events
module key_scan_to_midi_note_events_unit_tb;
  import kscan_pkg::*;

  localparam int unsigned NOTE_KEYS  = NOTE_KEYS_DEF;
  localparam int unsigned TOTAL_KEYS = NOTE_KEYS + 2;
  localparam int unsigned KEY_DOWN   = NOTE_KEYS;
  localparam int unsigned KEY_UP     = NOTE_KEYS + 1;
  localparam int unsigned KEY_W      = $clog2(TOTAL_KEYS);
  localparam int unsigned KEY_TOP    = (1 << KEY_W) - 1;
  localparam int unsigned SAMPLE_TOP = (1 << SAMPLE_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_OCT_LOWER + 1;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TIMEOUT_CYCLES = 500000;

  // one note event word
  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note_number;
    logic [NOTE_W-1:0] velocity;
  } note_event_t;

  // predicts note events from accepted samples and checks the event words
  class note_event_book;
    logic [SAMPLE_W-1:0] threshold;
    logic [NOTE_W-1:0]   velocity;
    logic [NOTE_W-1:0]   base;
    int                  oct_upper;
    int                  oct_lower;
    int                  octave;
    bit                  key_down[TOTAL_KEYS];
    logic [NOTE_W-1:0]   held[NOTE_KEYS];
    note_event_t         expected_q[$];
    int errors, ons_seen, offs_seen, clamped, oct_steps, reg_writes;

    function new();
      threshold = THRESH_RST;
      velocity  = VEL_RST;
      base      = BASE_RST;
      oct_upper = OCT_UP_RST;
      oct_lower = OCT_LO_RST;
      octave    = OCT_RST;
      foreach (key_down[i]) key_down[i] = 1'b0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_THRESHOLD: threshold = data[SAMPLE_W-1:0];
        CFG_VELOCITY:  velocity  = data[NOTE_W-1:0];
        CFG_BASE_NOTE: base      = data[NOTE_W-1:0];
        CFG_OCT_UPPER: oct_upper = $signed(data[OCT_W-1:0]);
        CFG_OCT_LOWER: oct_lower = $signed(data[OCT_W-1:0]);
        default: ;
      endcase
    endfunction

    // one accepted sample: update key and octave state, queue the event it causes
    function void note_sample(logic [KEY_W-1:0] key, logic [SAMPLE_W-1:0] smp);
      bit pressed, was;
      int note, b, k;
      note_event_t ev;
      pressed = smp > threshold;
      if (key >= TOTAL_KEYS) return;
      was = key_down[key];
      key_down[key] = pressed;
      if (key == KEY_UP) begin
        if (pressed && !was && octave < oct_upper) begin
          octave++;
          oct_steps++;
        end
        return;
      end
      if (key == KEY_DOWN) begin
        if (pressed && !was && octave > oct_lower) begin
          octave--;
          oct_steps++;
        end
        return;
      end
      if (pressed == was) return;
      // press stores the saturated note, release replays it
      if (pressed) begin
        b = base;
        k = key;
        note = 12 * octave + b + k;
        if (note > int'(NOTE_MAX)) begin
          note = NOTE_MAX;
          clamped++;
        end else if (note < 0) begin
          note = 0;
          clamped++;
        end
        held[key] = note[NOTE_W-1:0];
      end
      ev.note_on     = pressed;
      ev.note_number = held[key];
      ev.velocity    = velocity;
      expected_q.push_back(ev);
    endfunction

    function void check_event(note_event_t got);
      note_event_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected note event: note_on %0d note_number %0d velocity %0d",
               got.note_on, got.note_number, got.velocity);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.note_on) ons_seen++;
      else offs_seen++;
      if (got.note_on !== want.note_on) begin
        $error("note_on mismatch: expected %0d, actual %0d", want.note_on, got.note_on);
        errors++;
      end
      if (got.note_number !== want.note_number) begin
        $error("note_number mismatch: expected %0d, actual %0d",
               want.note_number, got.note_number);
        errors++;
      end
      if (got.velocity !== want.velocity) begin
        $error("velocity mismatch: expected %0d, actual %0d", want.velocity, got.velocity);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  kscan_cfg_if                   cfg_ch ();
  kscan_key_if #(.KEY_W(KEY_W))  key_ch ();
  kscan_event_if                 evt_ch ();

  key_scan_to_midi_note_events_unit #(
    .NOTE_KEYS(NOTE_KEYS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .key_i (key_ch),
    .evt_o (evt_ch)
  );

  note_event_book book = new();
  bit stalls_on = 1'b1;
  bit hold_out  = 1'b0;
  int samples_sent, settings_used;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(2 * TIMEOUT_CYCLES);
    $display("key_scan_to_midi_note_events_unit test failed");
    $finish;
  end

  // event receiver: random stalls, one long hold on request
  initial begin
    evt_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        evt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        evt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        evt_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // event monitor
  always @(posedge clk_i) begin
    if (rst_ni && evt_ch.valid && evt_ch.ready)
      book.check_event('{evt_ch.note_on, evt_ch.note_number, evt_ch.velocity});
  end

  // one key sample word, then maybe an idle burst
  task automatic send_sample(logic [KEY_W-1:0] key, logic [SAMPLE_W-1:0] smp, bit gaps);
    key_ch.valid     <= 1'b1;
    key_ch.key_index <= key;
    key_ch.sample    <= smp;
    do @(posedge clk_i); while (key_ch.ready !== 1'b1);
    book.note_sample(key, smp);
    samples_sent++;
    if (gaps && $urandom_range(0, 4) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    book.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every expected event is out and the pipeline is quiet
  task automatic settle();
    int waited;
    waited = 0;
    key_ch.valid <= 1'b0;
    while (book.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] vel,
                          logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] up,
                          logic [CFG_DATA_W-1:0] lo);
    settle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_VELOCITY, vel);
    write_reg(CFG_BASE_NOTE, base);
    write_reg(CFG_OCT_UPPER, up);
    write_reg(CFG_OCT_LOWER, lo);
    settings_used++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) return $urandom_range(0, NOTE_KEYS - 1);
    else if (r < 90) return KEY_DOWN;
    else if (r < 96) return KEY_UP;
    else return $urandom_range(TOTAL_KEYS, KEY_TOP);
  endfunction

  // samples mostly clearly above or below the threshold, some right at it
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] thr);
    int r, t;
    r = $urandom_range(0, 9);
    t = thr;
    if (r < 4 && t < SAMPLE_TOP) return $urandom_range(t + 1, SAMPLE_TOP);
    else if (r < 8) return $urandom_range(0, t);
    else if (r == 8) return thr + $urandom_range(0, 1);
    else return $urandom_range(0, SAMPLE_TOP);
  endfunction

  task automatic run_random(int count, bit gaps);
    repeat (count) send_sample(pick_key(), pick_sample(book.threshold), gaps);
  endtask

  task automatic random_regs();
    set_regs($urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP),
             $urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP),
             $urandom_range(0, SAMPLE_TOP));
    // writes to unused indexes change nothing
    write_reg(CFG_SPARE + $urandom_range(0, 2), $urandom_range(0, SAMPLE_TOP));
  endtask

  // stimulus
  initial begin
    rst_ni           = 1'b0;
    key_ch.valid     = 1'b0;
    key_ch.key_index = '0;
    key_ch.sample    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: press, release at the threshold, ignored keys, octave up
    send_sample(0, SAMPLE_TOP, 1);
    send_sample(0, THRESH_RST, 1);
    send_sample(NOTE_KEYS - 1, SAMPLE_TOP, 1);
    send_sample(KEY_TOP, SAMPLE_TOP, 1);
    send_sample(TOTAL_KEYS, SAMPLE_TOP, 1);
    send_sample(7, 0, 1);
    send_sample(KEY_UP, SAMPLE_TOP, 1);
    send_sample(KEY_UP, SAMPLE_TOP, 1);
    send_sample(KEY_UP, 0, 1);
    send_sample(NOTE_KEYS - 1, 0, 1);
    send_sample(NOTE_KEYS - 1, SAMPLE_TOP, 1);

    // top base and zero velocity: saturation high, octave held at both limits
    set_regs(12'd2047, 12'd0, 12'd127, 12'(4), 12'(2));
    send_sample(NOTE_KEYS - 1, 12'd2047, 1);
    send_sample(NOTE_KEYS - 1, 12'd2048, 1);
    send_sample(KEY_UP, 12'd4000, 1);
    send_sample(KEY_UP, 12'd5, 1);
    send_sample(KEY_DOWN, 12'd3000, 1);
    send_sample(KEY_DOWN, 12'd0, 1);
    send_sample(KEY_DOWN, 12'd3000, 1);
    send_sample(KEY_DOWN, 12'd0, 1);
    send_sample(KEY_DOWN, 12'd3000, 1);
    send_sample(3, SAMPLE_TOP, 1);
    send_sample(3, 12'd0, 1);

    // narrow octave range, with the receiver held off long enough to fill the block
    set_regs(12'd2048, 12'd64, 12'd60, 12'(2), 12'(-2));
    hold_out = 1'b1;
    run_random(30, 0);
    run_random(170, 1);

    // low extremes: every nonzero sample pressed, octave pulled to the bottom
    set_regs(12'd0, 12'd0, 12'd0, 12'(-16), 12'(-16));
    run_random(200, 1);

    // nothing counts as pressed: only releases of held keys
    set_regs(12'd4095, 12'd127, 12'd127, 12'(15), 12'(15));
    run_random(100, 1);

    // high extremes: octave free to climb, notes saturate
    set_regs(12'd100, 12'd1, 12'd127, 12'(15), 12'(-16));
    run_random(250, 1);

    // lower limit above the upper one
    set_regs(12'd3000, 12'd100, 12'd30, 12'(-3), 12'(5));
    run_random(200, 1);

    random_regs();
    run_random(220, 1);
    random_regs();
    run_random(220, 1);

    // last stretch without idling on either side
    random_regs();
    stalls_on = 1'b0;
    run_random(200, 0);

    settle();
    if (book.pending() != 0) begin
      $error("%0d expected note events never arrived", book.pending());
      book.errors++;
    end
    $display("%0d key samples over %0d settings, %0d register writes, %0d octave steps",
             samples_sent, settings_used, book.reg_writes, book.oct_steps);
    $display("%0d note-on and %0d note-off events checked, %0d with a clamped note",
             book.ons_seen, book.offs_seen, book.clamped);
    if (book.errors == 0) begin
      $display("key_scan_to_midi_note_events_unit test passed");
    end else begin
      $display("key_scan_to_midi_note_events_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/kscan_pkg.sv
hw/rtl/kscan_if.sv
hw/rtl/kscan_note_calc.sv
hw/rtl/key_scan_to_midi_note_events_unit.sv
sim/key_scan_to_midi_note_events_unit_tb.sv
